// File: rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants for the keypad code lock
// Payload structs for the three channels, request/key/result codes, limits.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // request types
  localparam logic [1:0] REQ_KEY  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_LIFT = 2'd2;

  // key codes
  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_STAR      = 4'd10;
  localparam logic [3:0] KEY_HASH      = 4'd11;

  // result codes
  localparam logic [2:0] RC_NONE    = 3'd0;
  localparam logic [2:0] RC_DIGIT   = 3'd1;
  localparam logic [2:0] RC_CLEARED = 3'd2;
  localparam logic [2:0] RC_WRONG   = 3'd3;
  localparam logic [2:0] RC_CORRECT = 3'd4;
  localparam logic [2:0] RC_IGNORED = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_CODE_WORD     = 2'd0;
  localparam logic [1:0] CFG_FAIL_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_DISABLE_TICKS = 2'd2;

  // saturation limits and register reset values
  localparam logic [3:0]  FAIL_MAX            = 4'd15;
  localparam logic [7:0]  TICK_MAX            = 8'd255;
  localparam logic [15:0] CODE_WORD_RST       = 16'h4321;
  localparam logic [3:0]  FAIL_LIMIT_RST      = 4'd3;
  localparam logic [7:0]  DISABLE_TICKS_RST   = 8'd15;
  localparam int          CODE_WORD_DIGITS    = 4;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_code;
    logic       lifted;
  } kcl_in_t;

  typedef struct packed {
    logic [2:0] result_code;
    logic       alarm_on;
    logic       alarm_disabled;
    logic [2:0] digits_entered;
    logic [3:0] failures;
  } kcl_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } kcl_cfg_t;

endpackage

// File: rtl/kcl_stream_if.sv
// ----------------------------------------------------------------------------
// kcl_stream_if: valid/ready channel
// One transaction moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface kcl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/keypad_code_lock_alarm.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_alarm: keypad code lock with alarm
// Handles key, timer-tick and lift events; one result transaction per event.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                        | accepted
//  ---------+-----+------------------------------------------------+----------------
//  in_if    | in  | req_type, key_code, lifted                     | valid && ready
//  out_if   | out | result_code, alarm_on, alarm_disabled,         | valid && ready
//           |     | digits_entered, failures                       |
//  cfg_if   | in  | index (0 code_word, 1 fail_limit,              | valid && ready
//           |     | 2 disable_ticks), data                         | (always ready)
//
//  One event per cycle while in_if.ready is high. The lock state is updated
//  and the result registered at the edge that accepts the event, so the
//  result shows in the next cycle. Ready drops only while the single output
//  register holds an untaken result and out_if.ready is low.
//  rst_n is synchronous, active low: counters, flags and valid are cleared,
//  configuration returns to code 16'h4321 (keyed 1-2-3-4), fail limit 3, 15 ticks.
//  The entry digits have no reset; only written positions are ever compared.
//
module keypad_code_lock_alarm
  import kcl_pkg::*;
#(
  parameter int CODE_LEN = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  kcl_stream_if.sink   in_if,
  kcl_stream_if.source out_if,
  kcl_stream_if.sink   cfg_if
);

  // entry count must hold CODE_LEN itself
  localparam int CNTW = $clog2(CODE_LEN + 1);

  // configuration
  logic [15:0] code_word_r;
  logic [3:0]  fail_limit_r;
  logic [7:0]  disable_ticks_r;

  // lock state
  logic [3:0]      entry_r [CODE_LEN];
  logic [CNTW-1:0] entry_cnt_r, entry_cnt_nxt;
  logic [3:0]      fail_cnt_r, fail_cnt_nxt;
  logic [7:0]      tick_cnt_r, tick_cnt_nxt;
  logic            disabled_r, disabled_nxt;
  logic            buzzer_r, buzzer_nxt;

  // result register
  logic     out_valid_r;
  kcl_out_t out_data_r;

  logic       in_fire;
  logic       digit_wr;
  logic       code_match;
  logic       entry_full;
  logic [2:0] rc;
  logic [3:0] fail_inc;
  logic [7:0] tick_inc;

  // accept whenever the result register is free or being drained
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  assign entry_full = (entry_cnt_r == CNTW'(CODE_LEN));
  assign fail_inc   = (fail_cnt_r < FAIL_MAX) ? fail_cnt_r + 4'd1 : fail_cnt_r;
  assign tick_inc   = (tick_cnt_r < TICK_MAX) ? tick_cnt_r + 8'd1 : tick_cnt_r;

  // parallel digit compare; positions past the code word expect zero
  always_comb begin
    code_match = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (i < CODE_WORD_DIGITS) begin
        if (entry_r[i] != code_word_r[4*i +: 4]) code_match = 1'b0;
      end else begin
        if (entry_r[i] != 4'd0) code_match = 1'b0;
      end
    end
  end

  // event decode
  always_comb begin
    entry_cnt_nxt = entry_cnt_r;
    fail_cnt_nxt  = fail_cnt_r;
    tick_cnt_nxt  = tick_cnt_r;
    disabled_nxt  = disabled_r;
    buzzer_nxt    = buzzer_r;
    digit_wr      = 1'b0;
    rc            = RC_NONE;
    case (in_if.data.req_type)
      REQ_KEY: begin
        if (disabled_r) begin
          rc = RC_IGNORED;
        end else if (in_if.data.key_code == KEY_STAR) begin
          entry_cnt_nxt = '0;
          rc            = RC_CLEARED;
        end else if (in_if.data.key_code == KEY_HASH) begin
          entry_cnt_nxt = '0;
          if (!entry_full) begin
            rc = RC_CLEARED;        // short entry: clear only
          end else if (code_match) begin
            rc           = RC_CORRECT;
            disabled_nxt = 1'b1;
            buzzer_nxt   = 1'b0;
            tick_cnt_nxt = '0;
            fail_cnt_nxt = '0;
          end else begin
            rc           = RC_WRONG;
            fail_cnt_nxt = fail_inc;
            if (fail_inc >= fail_limit_r) buzzer_nxt = 1'b1;
          end
        end else if (in_if.data.key_code > KEY_DIGIT_MAX) begin
          rc = RC_IGNORED;          // undefined key codes
        end else if (!entry_full) begin
          digit_wr      = 1'b1;
          entry_cnt_nxt = entry_cnt_r + CNTW'(1);
          rc            = RC_DIGIT;
        end else begin
          rc = RC_IGNORED;          // entry full, digit dropped
        end
      end
      REQ_TICK: begin
        tick_cnt_nxt = tick_inc;
        if (disabled_r && (tick_inc >= disable_ticks_r)) disabled_nxt = 1'b0;
      end
      REQ_LIFT: begin
        if (in_if.data.lifted) begin
          if (!disabled_r) buzzer_nxt = 1'b1;
        end else begin
          entry_cnt_nxt = '0;       // put down clears in either lock state
          rc            = RC_CLEARED;
        end
      end
      default: begin
        rc = RC_NONE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_cnt_r <= '0;
      fail_cnt_r  <= '0;
      tick_cnt_r  <= '0;
      disabled_r  <= 1'b0;
      buzzer_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        entry_cnt_r <= entry_cnt_nxt;
        fail_cnt_r  <= fail_cnt_nxt;
        tick_cnt_r  <= tick_cnt_nxt;
        disabled_r  <= disabled_nxt;
        buzzer_r    <= buzzer_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_word_r     <= CODE_WORD_RST;
      fail_limit_r    <= FAIL_LIMIT_RST;
      disable_ticks_r <= DISABLE_TICKS_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.data.index)
        CFG_CODE_WORD:     code_word_r     <= cfg_if.data.data;
        CFG_FAIL_LIMIT:    fail_limit_r    <= cfg_if.data.data[3:0];
        CFG_DISABLE_TICKS: disable_ticks_r <= cfg_if.data.data[7:0];
        default:           ;
      endcase
    end
  end

  // entry digits, written at the current count position
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODE_LEN; i++) begin
      if (in_fire && digit_wr && (entry_cnt_r == CNTW'(i))) begin
        entry_r[i] <= in_if.data.key_code;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.result_code    <= rc;
      out_data_r.alarm_on       <= buzzer_nxt;
      out_data_r.alarm_disabled <= disabled_nxt;
      out_data_r.digits_entered <= 3'(entry_cnt_nxt);
      out_data_r.failures       <= fail_cnt_nxt;
    end
  end

endmodule

// File: rtl/kcl_checker.sv
// ----------------------------------------------------------------------------
// kcl_checker: port-level checks for the code lock
// Watches the event and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker
  import kcl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input kcl_out_t out_data
);

  // every accepted event yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted event produced no result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a disabled lock never sounds the buzzer
  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alarm_disabled |-> !out_data.alarm_on)
    else $error("alarm on while lock disabled");

  // correct code: lock disabled, failure count and entry cleared
  a_correct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_code == RC_CORRECT) |->
      out_data.alarm_disabled && (out_data.failures == 4'd0) &&
      (out_data.digits_entered == 3'd0))
    else $error("correct code left state behind");

  // wrong code: entry cleared and at least one failure counted
  a_wrong: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_code == RC_WRONG) |->
      (out_data.digits_entered == 3'd0) && (out_data.failures != 4'd0))
    else $error("wrong code not counted");

endmodule

bind keypad_code_lock_alarm kcl_checker u_kcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
